/* rtl/core/adcdll_pkg.sv */
// ----------------------------------------------------------------------------
// adcdll_pkg
// Shared types and constants of the audio device clock delay-locked loop.
// ----------------------------------------------------------------------------
package adcdll_pkg;

  localparam int unsigned MAX_PERIOD_FRAMES = 8192;
  localparam logic [13:0] MAX_PERIOD       = 14'(MAX_PERIOD_FRAMES);
  localparam int unsigned STOP_SECONDS     = 30;

  localparam logic [63:0] NS_Q16_PER_S  = 64'd65536000000000;
  localparam logic [63:0] TWO_PI_BW_E15 = 64'd314159265358979;
  localparam logic [63:0] SQRT2_E15     = 64'd1414213562373095;
  localparam logic [63:0] E15           = 64'd1000000000000000;
  localparam logic [63:0] NS_PER_S      = 64'd1000000000;
  localparam logic [63:0] ERR_LIMIT_NS  = 64'd200000000;
  localparam logic [47:0] MASK48        = 48'hFFFF_FFFF_FFFF;

  localparam logic [17:0] RATE_RESET = 18'd48000;

  localparam logic [1:0] MODE_SETUP      = 2'd0;
  localparam logic [1:0] MODE_RUN        = 2'd1;
  localparam logic [1:0] MODE_KEEP_ALIVE = 2'd2;
  localparam logic [1:0] MODE_NO_BUFFER  = 2'd3;

  localparam logic CFG_SAMPLE_RATE  = 1'b0;
  localparam logic CFG_TARGET_START = 1'b1;

  typedef struct packed {
    logic [62:0]        now_ns;
    logic [13:0]        period_frames;
    logic signed [31:0] buffer_fill;
    logic [1:0]         stream_mode;
  } in_t;

  typedef struct packed {
    logic [13:0]        frames_read;
    logic signed [31:0] slew_frames;
    logic [62:0]        next_time_ns;
    logic signed [63:0] next_position;
    logic [13:0]        tick_period_frames;
    logic [1:0]         mode_after;
    logic               stop_request;
  } out_t;

endpackage

/* rtl/core/adcdll_mul.sv */
// ----------------------------------------------------------------------------
// adcdll_mul
// Bit-serial 64 x 64 multiplier, one multiplier bit per cycle, 128-bit product.
// ----------------------------------------------------------------------------
module adcdll_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  p
);

  logic [127:0] p_r;
  logic [63:0]  b_r;
  logic [5:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [64:0]  sum;

  assign sum = {1'b0, p_r[127:64]} + (b_r[0] ? {1'b0, a} : 65'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        b_r    <= b;
        p_r    <= '0;
        cnt_r  <= 6'd63;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= {sum, p_r[63:1]};
        b_r   <= {1'b0, b_r[63:1]};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

/* rtl/core/adcdll_div.sv */
// ----------------------------------------------------------------------------
// adcdll_div
// Restoring divider: round({hi,lo} / d) to nearest, one quotient bit per
// cycle; a quotient of 2^64 or more gives all ones.
// ----------------------------------------------------------------------------
module adcdll_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  hi,
  input  logic [63:0]  lo,
  input  logic [63:0]  d,
  output logic         done,
  output logic [63:0]  q
);

  typedef enum logic [1:0] {D_IDLE, D_ROUND, D_CHECK, D_ITER} dstate_t;

  dstate_t     state_r;
  logic [63:0] hi_r;
  logic [63:0] lo_r;
  logic [5:0]  cnt_r;
  logic        sat_r;
  logic        done_r;
  logic [64:0] lo_sum;
  logic [64:0] r65;
  logic        ge;
  logic [64:0] r_sub;

  assign lo_sum = {1'b0, lo_r} + {2'b0, d[63:1]};
  assign r65    = {hi_r, lo_r[63]};
  assign ge     = r65 >= {1'b0, d};
  assign r_sub  = r65 - {1'b0, d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      sat_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            hi_r    <= hi;
            lo_r    <= lo;
            sat_r   <= 1'b0;
            state_r <= D_ROUND;
          end
        end
        D_ROUND: begin
          lo_r    <= lo_sum[63:0];
          hi_r    <= hi_r + {63'd0, lo_sum[64]};
          state_r <= D_CHECK;
        end
        D_CHECK: begin
          if (hi_r >= d) begin
            sat_r   <= 1'b1;
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            cnt_r   <= 6'd63;
            state_r <= D_ITER;
          end
        end
        D_ITER: begin
          hi_r  <= ge ? r_sub[63:0] : r65[63:0];
          lo_r  <= {lo_r[62:0], ge};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = sat_r ? 64'hFFFF_FFFF_FFFF_FFFF : lo_r;

endmodule

/* rtl/core/audio_device_clock_dll.sv */
// ----------------------------------------------------------------------------
// audio_device_clock_dll
// Second-order delay-locked loop tracking an audio device clock from its
// pull requests, with a shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel  ports                              beat
//  in       in_valid / in_stall / in_data      one device pull
//  out      out_valid / out_stall / out_data   one loop update
//  cfg      cfg_wr_en / cfg_index / cfg_wdata  one register write
//
//  A pull with zero period or no buffer skips the arithmetic; tracking takes
//  two products, a slew on a large error a product, a quotient and a new
//  period, and a period change a new period and the loop coefficients. All
//  run on the serial multiplier and divider, one pull at a time.
//  Reset is synchronous: loop state clears, sample rate returns to 48000.
//  A stalled result holds in the output register; the next pull is taken
//  while it waits, and its result waits at the end of the sequence.
// ----------------------------------------------------------------------------
module audio_device_clock_dll (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [17:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  adcdll_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output adcdll_pkg::out_t  out_data
);
  import adcdll_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_NP_MUL, S_NP_DIV, S_NP_END, S_A_MUL, S_A_DIV, S_OM_DIV,
    S_B_MUL, S_B_DIV, S_C_MUL, S_ERR, S_M_MUL, S_M_DIV, S_SLEW, S_BT_MUL,
    S_CT_MUL, S_TRACK, S_TAIL, S_DONE
  } state_t;

  state_t             state_r;
  logic [17:0]        rate_r;
  logic [15:0]        target_r;
  logic [13:0]        last_period_r;
  logic [47:0]        period_est_r;
  logic [63:0]        wake_r;
  logic [63:0]        pos_r;
  logic [31:0]        coef_b_r;
  logic [31:0]        coef_c_r;
  logic [62:0]        now_r;
  logic [13:0]        f_r;
  logic signed [35:0] count_r;
  logic [1:0]         mode_r;
  logic [1:0]         mode_after_r;
  logic signed [34:0] slew_r;
  logic               neg_r;
  logic [63:0]        mag_r;
  logic [63:0]        omega_r;
  logic [45:0]        bt_r;
  logic [45:0]        ct_r;
  logic               np_slew_r;
  logic [13:0]        frames_res_r;
  logic signed [31:0] slew_out_r;
  logic               stop_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               mul_start_r;
  logic [63:0]        mul_a_r;
  logic [63:0]        mul_b_r;
  logic               div_start_r;
  logic [63:0]        div_hi_r;
  logic [63:0]        div_lo_r;
  logic [63:0]        div_d_r;
  logic               mul_done;
  logic [127:0]       mul_p;
  logic               div_done;
  logic [63:0]        div_q;

  logic               accept;
  logic [13:0]        f_in;
  logic [17:0]        rate_eff;
  logic signed [35:0] offset;
  logic [47:0]        pn_sat;
  logic               wake_keep;
  logic [47:0]        r16_src;
  logic [48:0]        r16_sum;
  logic [63:0]        wake_base;
  logic [63:0]        wake_np;
  logic [63:0]        d_err;
  logic [63:0]        mag;
  logic signed [31:0] s2;
  logic [61:0]        p_sum;
  logic [45:0]        p_rnd;
  logic signed [49:0] pe50;
  logic signed [49:0] bt50;
  logic signed [49:0] ct50;
  logic signed [49:0] step50;
  logic signed [49:0] pnt50;
  logic [49:0]        step_mag;
  logic [49:0]        step_sum;
  logic [63:0]        step_ns;
  logic [47:0]        pn_track;
  logic [31:0]        coef_b_sat;
  logic [33:0]        c_rnd;
  logic [31:0]        coef_c_sat;
  logic signed [35:0] count_tail;
  logic [22:0]        stop_thr;
  logic signed [35:0] stop_sum;
  logic               stop_hit;
  logic               slew_fits;
  logic signed [31:0] slew_sat;

  adcdll_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  adcdll_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .hi    (div_hi_r),
    .lo    (div_lo_r),
    .d     (div_d_r),
    .done  (div_done),
    .q     (div_q)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign f_in     = (in_data.period_frames > MAX_PERIOD) ? MAX_PERIOD
                                                         : in_data.period_frames;
  assign rate_eff = (rate_r == 18'd0) ? 18'd1 : rate_r;
  assign offset   = count_r - $signed({20'd0, target_r});

  assign pn_sat    = (div_q[63:48] != 16'd0) ? MASK48 : div_q[47:0];
  assign wake_keep = !np_slew_r && (last_period_r != 14'd0);
  assign r16_src   = wake_keep ? period_est_r : pn_sat;
  assign r16_sum   = {1'b0, r16_src} + 49'd32768;
  assign wake_base = wake_keep ? wake_r : {1'b0, now_r};
  assign wake_np   = wake_base + {31'd0, r16_sum[48:16]};

  assign d_err = {1'b0, now_r} - wake_r;
  assign mag   = d_err[63] ? (~d_err + 64'd1) : d_err;

  always_comb begin
    if (neg_r) begin
      s2 = (div_q[63:31] != 33'd0) ? 32'sh8000_0000
                                   : -$signed({1'b0, div_q[30:0]});
    end else begin
      s2 = (div_q[63:31] != 33'd0) ? 32'sh7FFF_FFFF
                                   : $signed({1'b0, div_q[30:0]});
    end
  end

  assign p_sum = {1'b0, mul_p[60:0]} + 62'd32768;
  assign p_rnd = p_sum[61:16];

  assign pe50     = $signed({2'b0, period_est_r});
  assign bt50     = $signed({4'b0, bt_r});
  assign ct50     = $signed({4'b0, ct_r});
  assign step50   = neg_r ? (pe50 - bt50) : (pe50 + bt50);
  assign pnt50    = neg_r ? (pe50 - ct50) : (pe50 + ct50);
  assign step_mag = step50[49] ? $unsigned(-step50) : $unsigned(step50);
  assign step_sum = {1'b0, step_mag[48:0]} + 50'd32768;
  assign step_ns  = step50[49] ? (64'd0 - {30'd0, step_sum[49:16]})
                               : {30'd0, step_sum[49:16]};
  assign pn_track = pnt50[49] ? 48'd0 : (pnt50[48] ? MASK48 : pnt50[47:0]);

  assign coef_b_sat = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
  assign c_rnd      = {1'b0, mul_p[63:31]} + 34'd1;
  assign coef_c_sat = ((mul_p[127:64] != 64'd0) || c_rnd[33]) ? 32'hFFFF_FFFF
                                                              : c_rnd[32:1];

  assign count_tail = count_r - $signed({22'd0, f_r});
  assign stop_thr   = 23'(rate_eff) * 23'(STOP_SECONDS);
  assign stop_sum   = count_tail + $signed({13'd0, stop_thr});
  assign stop_hit   = (mode_r == MODE_KEEP_ALIVE) && (stop_sum[35] || stop_sum == 36'sd0);
  assign slew_fits  = (slew_r[34:31] == 4'h0) || (slew_r[34:31] == 4'hF);
  assign slew_sat   = slew_fits ? slew_r[31:0]
                                : (slew_r[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rate_r        <= RATE_RESET;
      target_r      <= '0;
      last_period_r <= '0;
      period_est_r  <= '0;
      wake_r        <= '0;
      pos_r         <= '0;
      coef_b_r      <= '0;
      coef_c_r      <= '0;
      out_valid_r   <= 1'b0;
      mul_start_r   <= 1'b0;
      div_start_r   <= 1'b0;
      np_slew_r     <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SAMPLE_RATE:  rate_r   <= cfg_wdata;
          CFG_TARGET_START: target_r <= cfg_wdata[15:0];
          default:          rate_r   <= rate_r;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            now_r        <= in_data.now_ns;
            f_r          <= f_in;
            count_r      <= {{4{in_data.buffer_fill[31]}}, in_data.buffer_fill};
            mode_r       <= in_data.stream_mode;
            mode_after_r <= (in_data.stream_mode == MODE_SETUP && f_in != 14'd0)
                            ? MODE_RUN : in_data.stream_mode;
            slew_r       <= '0;
            slew_out_r   <= '0;
            frames_res_r <= '0;
            stop_r       <= 1'b0;
            state_r      <= S_START;
          end
        end
        S_START: begin
          if (f_r == 14'd0 || mode_r == MODE_NO_BUFFER) begin
            state_r <= S_DONE;
          end else begin
            if (mode_r == MODE_SETUP && offset < 0) begin
              pos_r   <= pos_r + {{28{offset[35]}}, offset};
              count_r <= $signed({20'd0, target_r});
              slew_r  <= offset[34:0];
            end
            if (f_r != last_period_r) begin
              mul_a_r     <= NS_Q16_PER_S;
              mul_b_r     <= {50'd0, f_r};
              mul_start_r <= 1'b1;
              np_slew_r   <= 1'b0;
              state_r     <= S_NP_MUL;
            end else begin
              state_r <= S_ERR;
            end
          end
        end
        S_NP_MUL: begin
          if (mul_done) begin
            div_hi_r    <= mul_p[127:64];
            div_lo_r    <= mul_p[63:0];
            div_d_r     <= {46'd0, rate_eff};
            div_start_r <= 1'b1;
            state_r     <= S_NP_DIV;
          end
        end
        S_NP_DIV: begin
          if (div_done) begin
            state_r <= S_NP_END;
          end
        end
        S_NP_END: begin
          wake_r       <= wake_np;
          period_est_r <= pn_sat;
          pos_r        <= pos_r + {50'd0, f_r};
          if (np_slew_r) begin
            state_r <= S_TAIL;
          end else begin
            last_period_r <= f_r;
            mul_a_r       <= TWO_PI_BW_E15;
            mul_b_r       <= {18'd0, f_r, 32'd0};
            mul_start_r   <= 1'b1;
            state_r       <= S_A_MUL;
          end
        end
        S_A_MUL: begin
          if (mul_done) begin
            div_hi_r    <= mul_p[127:64];
            div_lo_r    <= mul_p[63:0];
            div_d_r     <= E15;
            div_start_r <= 1'b1;
            state_r     <= S_A_DIV;
          end
        end
        S_A_DIV: begin
          if (div_done) begin
            div_hi_r    <= '0;
            div_lo_r    <= div_q;
            div_d_r     <= {46'd0, rate_eff};
            div_start_r <= 1'b1;
            state_r     <= S_OM_DIV;
          end
        end
        S_OM_DIV: begin
          if (div_done) begin
            omega_r     <= div_q;
            mul_a_r     <= div_q;
            mul_b_r     <= SQRT2_E15;
            mul_start_r <= 1'b1;
            state_r     <= S_B_MUL;
          end
        end
        S_B_MUL: begin
          if (mul_done) begin
            div_hi_r    <= mul_p[127:64];
            div_lo_r    <= mul_p[63:0];
            div_d_r     <= E15;
            div_start_r <= 1'b1;
            state_r     <= S_B_DIV;
          end
        end
        S_B_DIV: begin
          if (div_done) begin
            coef_b_r    <= coef_b_sat;
            mul_a_r     <= omega_r;
            mul_b_r     <= omega_r;
            mul_start_r <= 1'b1;
            state_r     <= S_C_MUL;
          end
        end
        S_C_MUL: begin
          if (mul_done) begin
            coef_c_r <= coef_c_sat;
            state_r  <= S_TAIL;
          end
        end
        S_ERR: begin
          mag_r       <= mag;
          neg_r       <= d_err[63];
          mul_start_r <= 1'b1;
          if (mag >= ERR_LIMIT_NS) begin
            mul_a_r <= mag;
            mul_b_r <= {46'd0, rate_eff};
            state_r <= S_M_MUL;
          end else begin
            mul_a_r <= {32'd0, coef_b_r};
            mul_b_r <= mag;
            state_r <= S_BT_MUL;
          end
        end
        S_M_MUL: begin
          if (mul_done) begin
            div_hi_r    <= mul_p[127:64];
            div_lo_r    <= mul_p[63:0];
            div_d_r     <= NS_PER_S;
            div_start_r <= 1'b1;
            state_r     <= S_M_DIV;
          end
        end
        S_M_DIV: begin
          if (div_done) begin
            state_r <= S_SLEW;
          end
        end
        S_SLEW: begin
          count_r     <= count_r - {{4{s2[31]}}, s2};
          slew_r      <= slew_r + {{3{s2[31]}}, s2};
          pos_r       <= pos_r + {{32{s2[31]}}, s2};
          mul_a_r     <= NS_Q16_PER_S;
          mul_b_r     <= {50'd0, f_r};
          mul_start_r <= 1'b1;
          np_slew_r   <= 1'b1;
          state_r     <= S_NP_MUL;
        end
        S_BT_MUL: begin
          if (mul_done) begin
            bt_r        <= p_rnd;
            mul_a_r     <= {32'd0, coef_c_r};
            mul_b_r     <= mag_r;
            mul_start_r <= 1'b1;
            state_r     <= S_CT_MUL;
          end
        end
        S_CT_MUL: begin
          if (mul_done) begin
            ct_r    <= p_rnd;
            state_r <= S_TRACK;
          end
        end
        S_TRACK: begin
          wake_r       <= wake_r + step_ns;
          period_est_r <= pn_track;
          pos_r        <= pos_r + {50'd0, f_r};
          state_r      <= S_TAIL;
        end
        S_TAIL: begin
          count_r      <= count_tail;
          frames_res_r <= f_r;
          slew_out_r   <= slew_sat;
          stop_r       <= stop_hit;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.frames_read        <= frames_res_r;
            out_data_r.slew_frames        <= slew_out_r;
            out_data_r.next_time_ns       <= wake_r[62:0];
            out_data_r.next_position      <= pos_r;
            out_data_r.tick_period_frames <= last_period_r;
            out_data_r.mode_after         <= mode_after_r;
            out_data_r.stop_request       <= stop_r;
            out_valid_r                   <= 1'b1;
            state_r                       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
